// ----- hdl/ssck_pkg.sv -----
package ssck_pkg;

  // Field widths fixed by the block's interface.
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 7;
  localparam int STEP_W      = 23;
  localparam int OFS_W       = 13;
  localparam int DEST_W      = 14;
  localparam int MODE_W      = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int COLOR_W     = 32;

  // 7.16 fixed point steps.
  localparam int STEP_FRAC = 16;
  localparam int PROD_W    = COORD_W + STEP_W;
  localparam int SRC_W     = PROD_W - STEP_FRAC;

  // Linear sprite address before it is checked against the store size.
  localparam int ADDR_CALC_W = 2 * SIZE_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_STEP        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_STEP        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COLOR     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_BITS     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y      = 3'd7;

  // Mode bit positions.
  localparam int MODE_KEY_EN   = 0;
  localparam int MODE_MIRROR_X = 1;
  localparam int MODE_MIRROR_Y = 2;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic                   hit;
    logic [ADDR_CALC_W-1:0] addr;
  } addr_res_t;

endpackage

// ----- hdl/ssck_ram.sv -----
module ssck_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/ssck_addr.sv -----
module ssck_addr
  import ssck_pkg::*;
#(
  parameter int STORE_WORDS = 4096
) (
  input  logic              is_draw,
  input  logic [SRC_W-1:0]  src_x,
  input  logic [SRC_W-1:0]  src_y,
  input  logic [SIZE_W-1:0] sprite_width,
  input  logic [SIZE_W-1:0] sprite_height,
  input  logic              mirror_x,
  input  logic              mirror_y,
  output addr_res_t         res
);

  logic                   in_sprite;
  logic [SIZE_W-1:0]      col;
  logic [SIZE_W-1:0]      row;
  logic [ADDR_CALC_W-1:0] addr;

  always_comb begin
    in_sprite = (src_x < SRC_W'(sprite_width)) && (src_y < SRC_W'(sprite_height));
    col       = src_x[SIZE_W-1:0];
    row       = src_y[SIZE_W-1:0];
    // Mirroring applies to draws only; inside the sprite the result stays in range.
    if (is_draw && mirror_x) begin
      col = sprite_width - SIZE_W'(1) - src_x[SIZE_W-1:0];
    end
    if (is_draw && mirror_y) begin
      row = sprite_height - SIZE_W'(1) - src_y[SIZE_W-1:0];
    end
    addr     = ADDR_CALC_W'(col) + ADDR_CALC_W'(row) * ADDR_CALC_W'(sprite_width);
    res.addr = addr;
    res.hit  = in_sprite && (32'(addr) < 32'(STORE_WORDS));
  end

endmodule

// ----- hdl/sprite_scaler_color_key.sv -----
// Sprite scaler with color key. Load transfers (in_req_type 0) write one
// color into the sprite store at column + row * sprite_width; loads outside
// the sprite or the store are dropped and give no result. Draw transfers
// (in_req_type 1) name one output pixel; it is mapped to a source pixel by
// nearest-neighbor scaling with 7.16 steps, optionally mirrored, read from
// the store and keyed against key_color. Each draw gives exactly one result
// with the translated destination, the color and a draw flag. The block takes
// one transfer per clock while the output is not stalled, and a draw result
// passes in order through the pipeline registers: the input register, scale
// multiply, address multiply with the store access, and the output register.
// The store is a single-port memory used by loads and
// draws in the same stage, so reads see every earlier load in order without
// forwarding. Its contents are undefined after reset; draws must only hit
// pixels that were loaded. Configuration may be written only while idle.
module sprite_scaler_color_key
  import ssck_pkg::*;
#(
  parameter int STORE_WORDS = 4096,
  parameter int COLOR_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic [COORD_W-1:0]       in_coord_x,
  input  logic [COORD_W-1:0]       in_coord_y,
  input  logic [COLOR_W-1:0]       in_pixel_color,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DEST_W-1:0] out_dest_x,
  output logic signed [DEST_W-1:0] out_dest_y,
  output logic [COLOR_W-1:0]       out_color,
  output logic                     out_draw
);

  localparam int ADDR_W = $clog2(STORE_WORDS);

  // Configuration registers.
  logic [SIZE_W-1:0]  sprite_width_r;
  logic [SIZE_W-1:0]  sprite_height_r;
  logic [STEP_W-1:0]  x_step_r;
  logic [STEP_W-1:0]  y_step_r;
  logic [COLOR_W-1:0] key_color_r;
  logic [MODE_W-1:0]  mode_bits_r;
  logic [OFS_W-1:0]   offset_x_r;
  logic [OFS_W-1:0]   offset_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_width_r  <= SIZE_W'(64);
      sprite_height_r <= SIZE_W'(64);
      x_step_r        <= STEP_W'(65536);
      y_step_r        <= STEP_W'(65536);
      key_color_r     <= '0;
      mode_bits_r     <= MODE_W'(1);
      offset_x_r      <= '0;
      offset_y_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_X_STEP:        x_step_r        <= cfg_wdata[STEP_W-1:0];
        CFG_Y_STEP:        y_step_r        <= cfg_wdata[STEP_W-1:0];
        CFG_KEY_COLOR:     key_color_r     <= cfg_wdata[COLOR_W-1:0];
        CFG_MODE_BITS:     mode_bits_r     <= cfg_wdata[MODE_W-1:0];
        CFG_OFFSET_X:      offset_x_r      <= cfg_wdata[OFS_W-1:0];
        CFG_OFFSET_Y:      offset_y_r      <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output register is
  // free or its result is being transferred this cycle.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage A: registered request.
  logic                  a_valid_r;
  logic                  a_draw_r;
  logic [COORD_W-1:0]    a_x_r;
  logic [COORD_W-1:0]    a_y_r;
  logic [COLOR_BITS-1:0] a_color_r;

  // Stage B: source coordinate (scaled for draws, raw for loads).
  logic                  b_valid_r;
  logic                  b_draw_r;
  logic [SRC_W-1:0]      b_sx_r;
  logic [SRC_W-1:0]      b_sy_r;
  logic [COLOR_BITS-1:0] b_color_r;
  logic [DEST_W-1:0]     b_dest_x_r;
  logic [DEST_W-1:0]     b_dest_y_r;

  // Stage C: store read in flight.
  logic                  c_valid_r;
  logic                  c_draw_r;
  logic                  c_hit_r;
  logic [DEST_W-1:0]     c_dest_x_r;
  logic [DEST_W-1:0]     c_dest_y_r;

  // Output register.
  logic                  out_valid_r;
  logic [DEST_W-1:0]     out_dest_x_r;
  logic [DEST_W-1:0]     out_dest_y_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic                  out_draw_r;

  // Scale multiply: source = (coordinate * step) >> 16.
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [SRC_W-1:0]  b_sx_nxt;
  logic [SRC_W-1:0]  b_sy_nxt;
  logic [DEST_W-1:0] b_dest_x_nxt;
  logic [DEST_W-1:0] b_dest_y_nxt;

  always_comb begin
    prod_x = PROD_W'(a_x_r) * PROD_W'(x_step_r);
    prod_y = PROD_W'(a_y_r) * PROD_W'(y_step_r);
    if (a_draw_r == REQ_DRAW) begin
      b_sx_nxt = prod_x[PROD_W-1:STEP_FRAC];
      b_sy_nxt = prod_y[PROD_W-1:STEP_FRAC];
    end else begin
      b_sx_nxt = SRC_W'(a_x_r);
      b_sy_nxt = SRC_W'(a_y_r);
    end
    // Destination is the unsigned output coordinate plus the signed offset.
    b_dest_x_nxt = DEST_W'(a_x_r) + {offset_x_r[OFS_W-1], offset_x_r};
    b_dest_y_nxt = DEST_W'(a_y_r) + {offset_y_r[OFS_W-1], offset_y_r};
  end

  // Stage B: bounds, mirror and linear address.
  addr_res_t b_res;

  ssck_addr #(
    .STORE_WORDS(STORE_WORDS)
  ) u_addr (
    .is_draw      (b_draw_r),
    .src_x        (b_sx_r),
    .src_y        (b_sy_r),
    .sprite_width (sprite_width_r),
    .sprite_height(sprite_height_r),
    .mirror_x     (mode_bits_r[MODE_MIRROR_X]),
    .mirror_y     (mode_bits_r[MODE_MIRROR_Y]),
    .res          (b_res)
  );

  logic [31:0]           addr_ext;
  logic [ADDR_W-1:0]     ram_addr;
  logic                  ram_we;
  logic                  ram_re;
  logic [COLOR_BITS-1:0] ram_rdata;

  assign addr_ext = 32'(b_res.addr);
  assign ram_addr = addr_ext[ADDR_W-1:0];
  assign ram_we   = adv && b_valid_r && (b_draw_r == REQ_LOAD) && b_res.hit;
  assign ram_re   = adv && b_valid_r && (b_draw_r == REQ_DRAW) && b_res.hit;

  ssck_ram #(
    .WIDTH(COLOR_BITS),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(b_color_r),
    .rdata(ram_rdata)
  );

  // Stage C to output: keying. The read data holds while the pipeline stalls
  // because the memory only updates it on a read.
  logic               out_valid_nxt;
  logic [COLOR_W-1:0] out_color_nxt;
  logic               out_draw_nxt;

  always_comb begin
    out_valid_nxt = c_valid_r && (c_draw_r == REQ_DRAW);
    if (c_hit_r) begin
      out_color_nxt = COLOR_W'(ram_rdata);
      out_draw_nxt  = !(mode_bits_r[MODE_KEY_EN] &&
                        (ram_rdata == key_color_r[COLOR_BITS-1:0]));
    end else begin
      out_color_nxt = '0;
      out_draw_nxt  = 1'b0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_draw_r     <= in_req_type;
      a_x_r        <= in_coord_x;
      a_y_r        <= in_coord_y;
      a_color_r    <= in_pixel_color[COLOR_BITS-1:0];

      b_draw_r     <= a_draw_r;
      b_sx_r       <= b_sx_nxt;
      b_sy_r       <= b_sy_nxt;
      b_color_r    <= a_color_r;
      b_dest_x_r   <= b_dest_x_nxt;
      b_dest_y_r   <= b_dest_y_nxt;

      c_draw_r     <= b_draw_r;
      c_hit_r      <= b_res.hit;
      c_dest_x_r   <= b_dest_x_r;
      c_dest_y_r   <= b_dest_y_r;

      out_dest_x_r <= c_dest_x_r;
      out_dest_y_r <= c_dest_y_r;
      out_color_r  <= out_color_nxt;
      out_draw_r   <= out_draw_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_dest_x = out_dest_x_r;
  assign out_dest_y = out_dest_y_r;
  assign out_color  = out_color_r;
  assign out_draw   = out_draw_r;

endmodule
